FILE: rtl/mmdp_pkg.sv
// ----------------------------------------------------------------------------
// mmdp_pkg: shared definitions of the min/max decimation pyramid
// Sizes, payload structs, state codes and the strict min/max merge function.
// ----------------------------------------------------------------------------
`default_nettype none

package mmdp_pkg;

  // Pyramid geometry.
  localparam int BRANCH      = 16;
  localparam int LEVELS      = 4;
  localparam int MAX_RESULTS = 8;

  // Field widths.
  localparam int X_W   = 32;
  localparam int Y_W   = 16;
  localparam int LVL_W = 2;

  // Fill counter only counts up to BRANCH-1 before it wraps to zero.
  localparam int FILL_W = $clog2(BRANCH);
  // Result counter must reach MAX_RESULTS itself.
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  // One bucket: the lowest-y point and the highest-y point.
  typedef struct packed {
    logic [X_W-1:0]        lx;
    logic signed [Y_W-1:0] ly;
    logic [X_W-1:0]        hx;
    logic signed [Y_W-1:0] hy;
  } mm_t;

  // Kind of token walking up the cell chain.
  typedef enum logic {
    TOK_INS,
    TOK_SNP
  } tok_kind_t;

  // Token handed from one cell to the next.
  typedef struct packed {
    logic      vld;
    tok_kind_t kind;
    logic      has;
    mm_t       mm;
  } tok_t;

  // Result offered by one cell in the cycle it acts.
  typedef struct packed {
    logic vld;
    logic complete;
    mm_t  mm;
  } res_t;

  // Result request into the output stage, tagged with its level.
  typedef struct packed {
    logic             vld;
    logic [LVL_W-1:0] level;
    logic             complete;
    mm_t              mm;
  } emit_req_t;

  // Result item as held in the output register.
  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             complete;
    logic             last;
    mm_t              mm;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_INSERT,
    SEQ_SNAP
  } seq_state_t;

  // Merge element e into accumulator acc; replace only on strict extremes.
  function automatic mm_t mm_merge(mm_t acc, mm_t e);
    mm_t r;
    r = acc;
    if (e.ly < acc.ly) begin
      r.lx = e.lx;
      r.ly = e.ly;
    end
    if (e.hy > acc.hy) begin
      r.hx = e.hx;
      r.hy = e.hy;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/mmdp_if.sv
// ----------------------------------------------------------------------------
// mmdp_if: valid/ready channels of the min/max decimation pyramid
// Sample channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmdp_in_if;
  logic                  valid;
  logic                  ready;
  logic [31:0]           sample_x;
  logic signed [15:0]    sample_y;
  logic                  restart;
  logic                  flush;

  modport source (output valid, output sample_x, output sample_y, output restart,
                  output flush, input ready);
  modport sink   (input valid, input sample_x, input sample_y, input restart,
                  input flush, output ready);
endinterface

interface mmdp_out_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            level;
  logic [31:0]           low_x;
  logic signed [15:0]    low_y;
  logic [31:0]           high_x;
  logic signed [15:0]    high_y;
  logic                  complete;
  logic                  last;

  modport source (output valid, output level, output low_x, output low_y,
                  output high_x, output high_y, output complete, output last,
                  input ready);
  modport sink   (input valid, input level, input low_x, input low_y,
                  input high_x, input high_y, input complete, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/mmdp_cell.sv
// ----------------------------------------------------------------------------
// mmdp_cell: one pyramid level
// Holds the running bucket and fill count of its level, acts on the token
// from the level below and hands the resulting token to the level above.
// ----------------------------------------------------------------------------
`default_nettype none

module mmdp_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          clear,
  input  wire mmdp_pkg::tok_t tok_i,
  output mmdp_pkg::tok_t     tok_o,
  output mmdp_pkg::res_t     res_o
);

  logic [mmdp_pkg::FILL_W-1:0] fill_r, fill_nxt;
  mmdp_pkg::mm_t               bkt_r, bkt_nxt;
  logic                        bkt_we;
  mmdp_pkg::tok_t              tok_r, tok_nxt;

  // Insert or snapshot work on the incoming token.
  always_comb begin
    logic          empty;
    logic          full;
    mmdp_pkg::mm_t cur;
    empty    = (fill_r == '0);
    full     = (fill_r == mmdp_pkg::FILL_W'(mmdp_pkg::BRANCH - 1));
    cur      = tok_i.mm;
    fill_nxt = fill_r;
    bkt_nxt  = bkt_r;
    bkt_we   = 1'b0;
    tok_nxt  = tok_i;
    res_o    = '0;
    if (tok_i.vld && tok_i.kind == mmdp_pkg::TOK_INS && tok_i.has) begin
      // The element seeds an empty bucket, otherwise it is merged in.
      if (!empty) begin
        cur = mmdp_pkg::mm_merge(bkt_r, tok_i.mm);
      end
      bkt_nxt      = cur;
      bkt_we       = 1'b1;
      fill_nxt     = full ? '0 : fill_r + 1'b1;
      tok_nxt.has  = full;
      tok_nxt.mm   = cur;
      res_o.vld    = full;
      res_o.complete = 1'b1;
      res_o.mm     = cur;
    end else if (tok_i.vld && tok_i.kind == mmdp_pkg::TOK_SNP) begin
      // The partial bucket is the older data and absorbs the child snapshot.
      if (!empty) begin
        cur         = tok_i.has ? mmdp_pkg::mm_merge(bkt_r, tok_i.mm) : bkt_r;
        tok_nxt.has = 1'b1;
      end
      tok_nxt.mm     = cur;
      res_o.vld      = tok_nxt.has;
      res_o.complete = 1'b0;
      res_o.mm       = cur;
    end
  end

  assign tok_o = tok_r;

  // Fill count and outgoing token.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      tok_r  <= '0;
    end else if (clear) begin
      fill_r <= '0;
    end else if (en) begin
      fill_r <= fill_nxt;
      tok_r  <= tok_nxt;
    end
  end

  // Bucket contents are only read while the fill count is non-zero.
  always_ff @(posedge clk) begin
    if (en && bkt_we) begin
      bkt_r <= bkt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mmdp_emit.sv
// ----------------------------------------------------------------------------
// mmdp_emit: result staging of the min/max decimation pyramid
// A pending register holds the newest result until the next one or the end
// of the item shows whether it is the last; the output register feeds the
// result channel and sets the stall for the whole chain.
// ----------------------------------------------------------------------------
`default_nettype none

module mmdp_emit (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clr,
  input  wire logic              fin,
  input  wire mmdp_pkg::emit_req_t req,
  output logic                   en,
  mmdp_out_if.source             out_ch
);

  mmdp_pkg::emit_req_t        pend_r;
  logic                       pend_vld_r;
  mmdp_pkg::out_item_t        out_r;
  logic                       out_vld_r;
  logic [mmdp_pkg::CNT_W-1:0] cnt_r;
  logic                       take;
  logic                       load;

  // The chain moves only when the output register is free this cycle.
  assign en   = !out_vld_r || out_ch.ready;
  assign take = en && req.vld && (cnt_r < mmdp_pkg::CNT_W'(mmdp_pkg::MAX_RESULTS));
  assign load = (take || (fin && en)) && pend_vld_r;

  // Control: valid flags and result count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (clr) begin
        cnt_r <= '0;
      end else if (take) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (take) begin
        pend_vld_r <= 1'b1;
      end else if (fin && en) begin
        pend_vld_r <= 1'b0;
      end
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (en) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload: a new result pushes the pending one out as not last.
  always_ff @(posedge clk) begin
    if (take) begin
      pend_r <= req;
    end
    if (load) begin
      out_r.level    <= pend_r.level;
      out_r.complete <= pend_r.complete;
      out_r.mm       <= pend_r.mm;
      out_r.last     <= !take;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.level    = out_r.level;
  assign out_ch.low_x    = out_r.mm.lx;
  assign out_ch.low_y    = out_r.mm.ly;
  assign out_ch.high_x   = out_r.mm.hx;
  assign out_ch.high_y   = out_r.mm.hy;
  assign out_ch.complete = out_r.complete;
  assign out_ch.last     = out_r.last;

endmodule

`default_nettype wire

FILE: rtl/minmax_decimation_pyramid_unit.sv
// ----------------------------------------------------------------------------
// minmax_decimation_pyramid_unit: min/max peak-detect decimation pyramid
// One cell per level keeps a running lowest/highest bucket; finished buckets
// and flush snapshots walk up the chain one level per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   in_ch    sink       sample_x, sample_y, restart, flush
//   out_ch   source     level, low_x, low_y, high_x, high_y, complete, last
//
// After a sample transfer the next transfer waits until an insert token, and
// with flush then a snapshot token, has walked the whole cell chain, one cell
// per cycle unless the result channel stalls.
// Reset is synchronous and active low; it empties every bucket.
// While the result channel stalls, the whole chain holds.
//
`default_nettype none

module minmax_decimation_pyramid_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mmdp_in_if.sink    in_ch,
  mmdp_out_if.source out_ch
);

  mmdp_pkg::seq_state_t state_r, state_nxt;
  mmdp_pkg::tok_t       chain [mmdp_pkg::LEVELS+1];
  mmdp_pkg::res_t       cres  [mmdp_pkg::LEVELS];
  mmdp_pkg::tok_t       tok0_r;
  mmdp_pkg::emit_req_t  req;
  logic                 flush_r;
  logic                 en;
  logic                 accept;
  logic                 ins_done;
  logic                 snp_done;
  logic                 launch_snap;
  logic                 fin;

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmdp_pkg::SEQ_IDLE: begin
        if (accept) state_nxt = mmdp_pkg::SEQ_INSERT;
      end
      mmdp_pkg::SEQ_INSERT: begin
        if (ins_done) state_nxt = flush_r ? mmdp_pkg::SEQ_SNAP : mmdp_pkg::SEQ_IDLE;
      end
      mmdp_pkg::SEQ_SNAP: begin
        if (snp_done) state_nxt = mmdp_pkg::SEQ_IDLE;
      end
      default: state_nxt = mmdp_pkg::SEQ_IDLE;
    endcase
  end

  // Sequencer: outputs. A phase ends when its token leaves the top cell.
  always_comb begin
    in_ch.ready = 1'b0;
    ins_done    = 1'b0;
    snp_done    = 1'b0;
    case (state_r)
      mmdp_pkg::SEQ_IDLE:   in_ch.ready = 1'b1;
      mmdp_pkg::SEQ_INSERT: ins_done    = en && chain[mmdp_pkg::LEVELS].vld;
      mmdp_pkg::SEQ_SNAP:   snp_done    = en && chain[mmdp_pkg::LEVELS].vld;
      default:              in_ch.ready = 1'b0;
    endcase
  end

  assign accept      = in_ch.valid && in_ch.ready;
  assign launch_snap = ins_done && flush_r;
  assign fin         = (ins_done && !flush_r) || snp_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmdp_pkg::SEQ_IDLE;
      tok0_r  <= '0;
    end else begin
      state_r <= state_nxt;
      // Token launch into level 0.
      if (accept) begin
        tok0_r.vld   <= 1'b1;
        tok0_r.kind  <= mmdp_pkg::TOK_INS;
        tok0_r.has   <= 1'b1;
        tok0_r.mm.lx <= in_ch.sample_x;
        tok0_r.mm.hx <= in_ch.sample_x;
        tok0_r.mm.ly <= in_ch.sample_y;
        tok0_r.mm.hy <= in_ch.sample_y;
      end else if (launch_snap) begin
        tok0_r.vld  <= 1'b1;
        tok0_r.kind <= mmdp_pkg::TOK_SNP;
        tok0_r.has  <= 1'b0;
      end else if (en) begin
        tok0_r.vld <= 1'b0;
      end
    end
  end

  // Flush request of the sample in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      flush_r <= in_ch.flush;
    end
  end

  assign chain[0] = tok0_r;

  // The row of level cells.
  for (genvar k = 0; k < mmdp_pkg::LEVELS; k++) begin : g_cell
    mmdp_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .clear (accept && in_ch.restart),
      .tok_i (chain[k]),
      .tok_o (chain[k+1]),
      .res_o (cres[k])
    );
  end

  // Only one cell holds a token at a time; pick its result and tag the level.
  always_comb begin
    req = '0;
    for (int k = 0; k < mmdp_pkg::LEVELS; k++) begin
      if (cres[k].vld) begin
        req.vld      = 1'b1;
        req.level    = mmdp_pkg::LVL_W'(k);
        req.complete = cres[k].complete;
        req.mm       = cres[k].mm;
      end
    end
  end

  mmdp_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (accept),
    .fin    (fin),
    .req    (req),
    .en     (en),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

FILE: rtl/mmdp_checker.sv
// ----------------------------------------------------------------------------
// mmdp_checker: port-level checks of the min/max decimation pyramid
// Watches both channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module mmdp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_level,
  input wire logic [31:0] out_low_x,
  input wire logic [15:0] out_low_y,
  input wire logic [31:0] out_high_x,
  input wire logic [15:0] out_high_y,
  input wire logic        out_complete,
  input wire logic        out_last
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) &&
      $stable(out_low_x) && $stable(out_low_y) && $stable(out_high_x) &&
      $stable(out_high_y) && $stable(out_complete) && $stable(out_last))
    else $error("result changed while stalled");

  // A sample transfer makes the block busy in the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a sample transfer");

  // While a result that is not the last waits, no new sample is taken.
  a_no_take_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("ready high while results of a sample remain");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind minmax_decimation_pyramid_unit mmdp_checker u_mmdp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_level    (out_ch.level),
  .out_low_x    (out_ch.low_x),
  .out_low_y    (out_ch.low_y),
  .out_high_x   (out_ch.high_x),
  .out_high_y   (out_ch.high_y),
  .out_complete (out_ch.complete),
  .out_last     (out_ch.last)
);

`default_nettype wire
